>>> hdl/qpd_pkg.sv
package qpd_pkg;

    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam int unsigned HEX_BASE = 16;
    localparam int unsigned MAX_RESULTS = 3;

    typedef logic [1:0] held_t;
    localparam held_t HELD_NONE = 2'd0;
    localparam held_t HELD_EQ   = 2'd1;
    localparam held_t HELD_TWO  = 2'd2;

    typedef logic [1:0] res_cnt_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       message_end;
    } result_t;

    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        res_cnt_t                  n;
        held_t                     held_count;
        logic [7:0]                held_second;
    } dec_t;

    // {valid, nibble}; valid clear when the byte is not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        return v;
    endfunction

endpackage

>>> hdl/qpd_stream_if.sv
interface qpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface qpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       message_end;

    modport source (output valid, output out_byte, output has_byte, output run_last,
                    output message_end, input ready);
    modport sink (input valid, input out_byte, input has_byte, input run_last,
                  input message_end, output ready);
endinterface

>>> hdl/qpd_decode.sv
module qpd_decode (
    input  logic [7:0]          in_byte,
    input  logic                in_last,
    input  qpd_pkg::held_t      held_count,
    input  logic [7:0]          held_second,
    output qpd_pkg::dec_t       dec
);
    import qpd_pkg::*;

    logic [4:0] hv1;
    logic [4:0] hv2;
    res_cnt_t   n;
    held_t      hc;
    logic [7:0] hs;

    assign hv1 = hex_value(held_second);
    assign hv2 = hex_value(in_byte);

    always_comb
    begin
        dec = '0;
        n   = '0;
        hc  = HELD_NONE;
        hs  = '0;

        if (held_count == HELD_EQ)
        begin
            hc = HELD_TWO;
            hs = in_byte;
        end
        else if (held_count == HELD_TWO)
        begin
            if (held_second == CH_CR && in_byte == CH_LF)
            begin
                // soft line break: drop
            end
            else if (hv1[4] && hv2[4])
            begin
                dec.res[n] = '{out_byte: {hv1[3:0], hv2[3:0]}, has_byte: 1'b1,
                               run_last: 1'b0, message_end: 1'b0};
                n = n + 2'd1;
            end
            else
            begin
                dec.res[n] = '{out_byte: CH_EQ, has_byte: 1'b1,
                               run_last: 1'b0, message_end: 1'b0};
                n = n + 2'd1;
                if (held_second == CH_EQ)
                begin
                    // second '=' opens a new escape with this byte held
                    hc = HELD_TWO;
                    hs = in_byte;
                end
                else
                begin
                    dec.res[n] = '{out_byte: held_second, has_byte: 1'b1,
                                   run_last: 1'b0, message_end: 1'b0};
                    n = n + 2'd1;
                    if (in_byte == CH_EQ)
                    begin
                        hc = HELD_EQ;
                    end
                    else
                    begin
                        dec.res[n] = '{out_byte: in_byte, has_byte: 1'b1,
                                       run_last: 1'b0, message_end: 1'b0};
                        n = n + 2'd1;
                    end
                end
            end
        end
        else
        begin
            if (in_byte == CH_EQ)
            begin
                hc = HELD_EQ;
            end
            else
            begin
                dec.res[n] = '{out_byte: in_byte, has_byte: 1'b1,
                               run_last: 1'b0, message_end: 1'b0};
                n = n + 2'd1;
            end
        end

        if (in_last)
        begin
            // flush held bytes literally
            if (hc != HELD_NONE)
            begin
                dec.res[n] = '{out_byte: CH_EQ, has_byte: 1'b1,
                               run_last: 1'b0, message_end: 1'b0};
                n = n + 2'd1;
            end
            if (hc == HELD_TWO)
            begin
                dec.res[n] = '{out_byte: hs, has_byte: 1'b1,
                               run_last: 1'b0, message_end: 1'b0};
                n = n + 2'd1;
            end
            hc = HELD_NONE;
            hs = '0;
            if (n == 2'd0)
            begin
                dec.res[0] = '0;
                n = 2'd1;
            end
            dec.res[n - 2'd1].message_end = 1'b1;
        end

        if (n != 2'd0)
        begin
            dec.res[n - 2'd1].run_last = 1'b1;
        end

        dec.n           = n;
        dec.held_count  = hc;
        dec.held_second = hs;
    end

endmodule

>>> hdl/qpd_out_buf.sv
module qpd_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  qpd_pkg::dec_t        dec,
    output logic                 can_load,
    qpd_out_if.source            dst
);
    import qpd_pkg::*;

    result_t [MAX_RESULTS-1:0] res_reg;
    res_cnt_t                  cnt_reg;
    res_cnt_t                  idx_reg;
    result_t                   cur;
    logic                      pop;

    assign cur  = res_reg[idx_reg];
    assign pop  = dst.valid && dst.ready;

    assign dst.valid       = (cnt_reg != 2'd0);
    assign dst.out_byte    = cur.out_byte;
    assign dst.has_byte    = cur.has_byte;
    assign dst.run_last    = cur.run_last;
    assign dst.message_end = cur.message_end;

    // take a new transaction when empty or when the last pending result leaves now
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && dst.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load && dec.n != 2'd0)
        begin
            cnt_reg <= dec.n;
            idx_reg <= '0;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
            idx_reg <= (cnt_reg == 2'd1) ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && dec.n != 2'd0)
        begin
            res_reg <= dec.res;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, cnt_reg} + {1'b0, idx_reg}) <= 3'(MAX_RESULTS))
        else $error("result buffer index beyond loaded results");

    assert property (@(posedge clk) disable iff (!rst_n)
        dst.valid && dst.message_end |-> dst.run_last)
        else $error("message end without run end");

    assert property (@(posedge clk) disable iff (!rst_n)
        dst.valid && !dst.has_byte |-> dst.message_end && dst.run_last)
        else $error("empty result that is not an end marker");

    assert property (@(posedge clk) disable iff (!rst_n)
        dst.valid && !dst.run_last |=> dst.valid)
        else $error("run of results broken off");

endmodule

>>> hdl/quoted_printable_decoder_top.sv
// Quoted-printable decoder: one encoded byte in, up to three decoded bytes out.
// The first result of a byte is presented in the cycle after its input transaction.
// Bytes are taken one per cycle while each byte yields at most one result and the
// output port is ready; a byte yielding several results stalls the input while
// the output port drains one result a cycle, as long as the port is ready.
// Reset (rst_n, async low) clears held escape state and drops pending results.
module quoted_printable_decoder_top (
    input  logic       clk,
    input  logic       rst_n,
    qpd_in_if.sink     enc,
    qpd_out_if.source  dec_out
);
    import qpd_pkg::*;

    held_t      held_count_reg;
    logic [7:0] held_second_reg;
    dec_t       dec;
    logic       can_load;
    logic       accept;

    assign enc.ready = can_load;
    assign accept    = enc.valid && enc.ready;

    qpd_decode u_decode (
        .in_byte     (enc.in_byte),
        .in_last     (enc.in_last),
        .held_count  (held_count_reg),
        .held_second (held_second_reg),
        .dec         (dec)
    );

    qpd_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .dec      (dec),
        .can_load (can_load),
        .dst      (dec_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg  <= HELD_NONE;
            held_second_reg <= '0;
        end
        else if (accept)
        begin
            held_count_reg  <= dec.held_count;
            held_second_reg <= dec.held_second;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && enc.in_last |=> held_count_reg == HELD_NONE)
        else $error("escape state survived end of message");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && enc.in_last |-> dec.n != 2'd0)
        else $error("final byte produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && dec.n != 2'd0 |=> dec_out.valid)
        else $error("decoded results not presented");

endmodule

>>> dv/quoted_printable_decoder_top_test.sv
module quoted_printable_decoder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import qpd_pkg::*;

    class decode_scoreboard;
        held_t      held_count;
        logic [7:0] held_second;
        result_t    step_out[MAX_RESULTS];
        int         step_n;
        result_t    expected_bytes[$];
        int         errors;
        int         bytes_in;
        int         results_out;
        int         markers_out;

        function new();
            held_count  = HELD_NONE;
            held_second = '0;
            step_n      = 0;
            errors      = 0;
            bytes_in    = 0;
            results_out = 0;
            markers_out = 0;
        endfunction

        function bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
            v = '0;
            if (c >= "0" && c <= "9")
            begin
                v = 4'(c - "0");
                return 1'b1;
            end
            if (c >= "A" && c <= "F")
            begin
                v = 4'(c - "A" + 8'd10);
                return 1'b1;
            end
            if (c >= "a" && c <= "f")
            begin
                v = 4'(c - "a" + 8'd10);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void emit(input logic [7:0] b);
            step_out[step_n] = '{out_byte: b, has_byte: 1'b1, run_last: 1'b0,
                                 message_end: 1'b0};
            step_n++;
        endfunction

        function void take_fresh(input logic [7:0] b);
            if (b == CH_EQ)
            begin
                held_count = HELD_EQ;
            end
            else
            begin
                emit(b);
            end
        endfunction

        // Work out the decoded results of one accepted encoded byte.
        function void predict_decode(input logic [7:0] b, input logic last);
            logic [7:0] c1;
            logic [3:0] hi;
            logic [3:0] lo;
            bit         hi_ok;
            bit         lo_ok;
            step_n = 0;
            bytes_in++;
            case (held_count)
                HELD_EQ:
                begin
                    held_second = b;
                    held_count  = HELD_TWO;
                end
                HELD_TWO:
                begin
                    c1          = held_second;
                    held_count  = HELD_NONE;
                    held_second = '0;
                    hi_ok       = hex_nibble(c1, hi);
                    lo_ok       = hex_nibble(b, lo);
                    if (c1 == CH_CR && b == CH_LF)
                    begin
                        // soft line break: drop
                    end
                    else if (hi_ok && lo_ok)
                    begin
                        emit({hi, lo});
                    end
                    else
                    begin
                        emit(CH_EQ);
                        if (c1 == CH_EQ)
                        begin
                            // second '=' opens a new escape
                            held_second = b;
                            held_count  = HELD_TWO;
                        end
                        else
                        begin
                            emit(c1);
                            take_fresh(b);
                        end
                    end
                end
                default:
                begin
                    held_count = HELD_NONE;
                    take_fresh(b);
                end
            endcase

            if (last)
            begin
                // flush whatever escape is still open
                if (held_count != HELD_NONE)
                begin
                    emit(CH_EQ);
                end
                if (held_count == HELD_TWO)
                begin
                    emit(held_second);
                end
                held_count  = HELD_NONE;
                held_second = '0;
                if (step_n == 0)
                begin
                    step_out[0] = '0;
                    step_n      = 1;
                end
                step_out[step_n-1].message_end = 1'b1;
            end
            if (step_n > 0)
            begin
                step_out[step_n-1].run_last = 1'b1;
            end
            for (int i = 0; i < step_n; i++)
            begin
                expected_bytes.insert(expected_bytes.size(), step_out[i]);
            end
        endfunction

        function void compare_field(input string name, input logic [7:0] want,
                                    input logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %02h, actual %02h",
                         $time, name, want, got);
            end
        endfunction

        function void check_decoded(input result_t got);
            result_t want;
            results_out++;
            if (!got.has_byte)
            begin
                markers_out++;
            end
            if (expected_bytes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %02h/%0b/%0b/%0b",
                         $time, got.out_byte, got.has_byte, got.run_last, got.message_end);
                return;
            end
            want = expected_bytes.pop_front();
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
            compare_field("run_last", 8'(want.run_last), 8'(got.run_last));
            compare_field("message_end", 8'(want.message_end), 8'(got.message_end));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    qpd_in_if  enc_if();
    qpd_out_if dec_if();

    quoted_printable_decoder_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .enc     (enc_if),
        .dec_out (dec_if)
    );

    decode_scoreboard sb = new();

    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    int    messages_sent = 0;
    string hex_digits = "0123456789ABCDEFabcdef";

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [7:0] hex_char();
        return hex_digits[$urandom_range(21)];
    endfunction

    // Call at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            enc_if.valid <= 1'b0;
            @(negedge clk);
        end
        enc_if.valid   <= 1'b1;
        enc_if.in_byte <= b;
        enc_if.in_last <= last;
        @(posedge clk);
        while (!enc_if.ready)
        begin
            @(posedge clk);
        end
        sb.predict_decode(b, last);
        @(negedge clk);
    endtask

    task automatic send_message(input logic [7:0] msg[$]);
        for (int i = 0; i < msg.size(); i++)
        begin
            send_byte(msg[i], i == msg.size() - 1);
        end
        messages_sent++;
    endtask

    task automatic send_text(input string s);
        logic [7:0] msg[$];
        for (int i = 0; i < s.len(); i++)
        begin
            msg.insert(msg.size(), s[i]);
        end
        send_message(msg);
    endtask

    initial
    begin
        dec_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            dec_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && dec_if.valid && dec_if.ready)
        begin
            sb.check_decoded('{out_byte: dec_if.out_byte, has_byte: dec_if.has_byte,
                               run_last: dec_if.run_last,
                               message_end: dec_if.message_end});
        end
    end

    initial
    begin
        logic [7:0] msg[$];
        int         tokens;
        int         kind;
        int         sent;
        int         guard;

        rst_n          = 1'b0;
        enc_if.valid   = 1'b0;
        enc_if.in_byte = '0;
        enc_if.in_last = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 18;
        recv_idle_pct = 58;

        // hex escapes at both extremes and both letter cases
        send_text("=00=ff=4A");
        // soft line break, then a plain byte
        send_text("=\015\nb");
        // bad escape, then '=' restarting an escape
        send_text("=G1==41");
        // short escapes cut off by the end of the message
        send_text("=");
        send_text("=4");
        // soft break as the final bytes: end marker only
        send_text("=\015\n");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        messages_sent++;

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 18;
                    recv_idle_pct = 58;
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_idle_pct = 18;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < 110)
            begin
                msg.delete();
                tokens = $urandom_range(6, 1);
                repeat (tokens)
                begin
                    kind = $urandom_range(99);
                    if (kind < 40)
                    begin
                        msg.insert(msg.size(), 8'($urandom_range(255)));
                    end
                    else if (kind < 70)
                    begin
                        msg.insert(msg.size(), CH_EQ);
                        msg.insert(msg.size(), hex_char());
                        msg.insert(msg.size(), hex_char());
                    end
                    else if (kind < 80)
                    begin
                        msg.insert(msg.size(), CH_EQ);
                        msg.insert(msg.size(), CH_CR);
                        msg.insert(msg.size(), CH_LF);
                    end
                    else if (kind < 90)
                    begin
                        msg.insert(msg.size(), CH_EQ);
                        msg.insert(msg.size(), 8'($urandom_range(255)));
                        msg.insert(msg.size(), 8'($urandom_range(255)));
                    end
                    else if (kind < 95)
                    begin
                        msg.insert(msg.size(), CH_EQ);
                        msg.insert(msg.size(), CH_EQ);
                        msg.insert(msg.size(), hex_char());
                        msg.insert(msg.size(), hex_char());
                    end
                    else
                    begin
                        // broken soft break
                        msg.insert(msg.size(), CH_EQ);
                        msg.insert(msg.size(), CH_CR);
                        msg.insert(msg.size(), 8'($urandom_range(255)));
                    end
                end
                send_message(msg);
                sent += msg.size();
            end
        end
        enc_if.valid <= 1'b0;

        guard = 0;
        while (sb.expected_bytes.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        if (sb.expected_bytes.size() != 0)
        begin
            sb.errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     sb.expected_bytes.size());
        end
        repeat (20) @(posedge clk);

        $display("run covered %0d encoded bytes in %0d messages under three stall mixes",
                 sb.bytes_in, messages_sent);
        $display("checked %0d decoded results, %0d of them end markers",
                 sb.results_out, sb.markers_out);
        if (sb.errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
